[rtl/pwltrt_pkg.sv]
// Package for the pulse-width line timer: phase and action codes,
// configuration register indexes and field widths.
// No dependencies; used by the top level and its checker.
`default_nettype none

package pwltrt_pkg;

  // Widths of the transaction fields
  localparam int unsigned EntryIdxW  = 6;
  localparam int unsigned TicksW     = 32;
  localparam int unsigned PhaseW     = 3;
  localparam int unsigned CapIdxW    = 6;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned PulseCntW  = 7;

  // Default table and reply depths
  localparam int unsigned SendDepthDef = 64;
  localparam int unsigned RecDepthDef  = 64;

  // Width used for small unsigned compares (holds up to 511)
  localparam int unsigned CmpW = 9;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_START = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_EDGE  = 2'd3
  } action_e;

  typedef enum logic [PhaseW-1:0] {
    PH_IDLE    = 3'd0,
    PH_SEND    = 3'd1,
    PH_DELAY   = 3'd2,
    PH_WAIT    = 3'd3,
    PH_END     = 3'd4,
    PH_TIMEOUT = 3'd5
  } phase_e;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FIXED_MODE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PULSE_COUNT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_EXPECT_REPLY = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_REPLY_DELAY  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RX_TIMEOUT   = 3'd4;

endpackage

`default_nettype wire

[rtl/pulse_width_line_tx_rx_timer_top.sv]
// Top level of the pulse-width line timer: send sequencer, receive
// capture and the duration memory. Depends on pwltrt_pkg.
`default_nettype none

//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+--------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tuser: action; tdata: entry
//            |           |                              | index, duration value
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tuser: capture_valid; tdata:
//            |           |                              | line, phase, interval, index
//  cfg       | in        | cfg_we_i (no wait)           | cfg_idx_i, cfg_data_i
//
// One transaction is accepted per cycle; its result sits in the output register from the
// next cycle. A new transaction is taken only while that register is empty or its result
// leaves in the same cycle. A start drops s_axis_tready for one cycle while entry 0 comes
// out of the duration memory (one read port, registered read). The next period's length
// is read ahead with write-first forwarding, so period ends never stall.
// Reset clears all control state; the duration memory holds garbage until written.

module pulse_width_line_tx_rx_timer_top #(
  parameter int unsigned SEND_DEPTH = pwltrt_pkg::SendDepthDef,
  parameter int unsigned REC_DEPTH  = pwltrt_pkg::RecDepthDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [39:0]                      s_axis_tdata,  // entry_index, duration_value
  input  wire logic [1:0]                       s_axis_tuser,  // action
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [47:0]                           m_axis_tdata,  // line_level, phase,
                                                               // capture_interval, capture_index
  output logic [0:0]                            m_axis_tuser,  // capture_valid
  // configuration writes
  input  wire logic                             cfg_we_i,
  input  wire logic [pwltrt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [pwltrt_pkg::TicksW-1:0]    cfg_data_i
);

  localparam int unsigned AW    = $clog2(SEND_DEPTH);
  localparam int unsigned POS_W = $clog2(SEND_DEPTH + 1);
  localparam int unsigned CAP_W = $clog2(REC_DEPTH + 1);
  localparam int unsigned CMP_W = pwltrt_pkg::CmpW;
  localparam int unsigned TW    = pwltrt_pkg::TicksW;

  // ---------------------------------------------------------------------------
  // Input fields
  // ---------------------------------------------------------------------------
  pwltrt_pkg::action_e                   act;
  logic [pwltrt_pkg::EntryIdxW-1:0]      in_entry;
  logic [TW-1:0]                         in_dur;
  logic                                  in_acc;

  assign act      = pwltrt_pkg::action_e'(s_axis_tuser);
  assign in_entry = s_axis_tdata[5:0];
  assign in_dur   = s_axis_tdata[37:6];

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                                  fixed_q, fixed_d;
  logic [pwltrt_pkg::PulseCntW-1:0]      pcount_q, pcount_d;
  logic                                  expect_q, expect_d;
  logic [TW-1:0]                         rdelay_q, rdelay_d;
  logic [TW-1:0]                         rtimeout_q, rtimeout_d;

  always_comb begin
    fixed_d    = fixed_q;
    pcount_d   = pcount_q;
    expect_d   = expect_q;
    rdelay_d   = rdelay_q;
    rtimeout_d = rtimeout_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pwltrt_pkg::CFG_FIXED_MODE:   fixed_d    = cfg_data_i[0];
        pwltrt_pkg::CFG_PULSE_COUNT:  pcount_d   = cfg_data_i[pwltrt_pkg::PulseCntW-1:0];
        pwltrt_pkg::CFG_EXPECT_REPLY: expect_d   = cfg_data_i[0];
        pwltrt_pkg::CFG_REPLY_DELAY:  rdelay_d   = cfg_data_i;
        pwltrt_pkg::CFG_RX_TIMEOUT:   rtimeout_d = cfg_data_i;
        default: ;  // indexes beyond the register list are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fixed_q    <= 1'b0;
      pcount_q   <= '0;
      expect_q   <= 1'b0;
      rdelay_q   <= TW'(1);
      rtimeout_q <= '1;
    end else begin
      fixed_q    <= fixed_d;
      pcount_q   <= pcount_d;
      expect_q   <= expect_d;
      rdelay_q   <= rdelay_d;
      rtimeout_q <= rtimeout_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  pwltrt_pkg::phase_e    phase_q, phase_d;
  logic                  line_q, line_d;
  logic [POS_W-1:0]      spos_q, spos_d;
  logic [TW-1:0]         pcnt_q, pcnt_d;
  logic                  rx_run_q, rx_run_d;
  logic [CAP_W-1:0]      rx_cap_q, rx_cap_d;
  logic [TW-1:0]         edge_q, edge_d;
  logic                  ld_pend_q, ld_pend_d;   // entry 0 arriving from memory

  // Duration memory: one write port, one registered read port
  logic [TW-1:0]         dur_mem [SEND_DEPTH];
  logic [TW-1:0]         rd_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [AW-1:0]         mem_raddr;

  // Derived values
  logic [CMP_W-1:0]      cnt_eff;
  logic [CMP_W-1:0]      spos_ext;
  logic [CMP_W-1:0]      entry_ext;
  logic [CMP_W-1:0]      cap_ext;
  logic [TW-1:0]         edge_inc;

  // Result fields
  logic                  cap_v;
  logic [TW-1:0]         cap_int;
  logic [pwltrt_pkg::CapIdxW-1:0] cap_idx;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Clamp the pulse count to the table depth
  always_comb begin
    cnt_eff = CMP_W'(pcount_q);
    if (cnt_eff > CMP_W'(SEND_DEPTH)) begin
      cnt_eff = CMP_W'(SEND_DEPTH);
    end
  end

  assign spos_ext  = CMP_W'(spos_q);
  assign entry_ext = CMP_W'(in_entry);
  assign cap_ext   = CMP_W'(rx_cap_q);
  assign edge_inc  = edge_q + TW'(1);
  assign mem_waddr = entry_ext[AW-1:0];

  // Result of the current transaction: a measured interval, if any
  always_comb begin
    cap_v   = 1'b0;
    cap_int = '0;
    cap_idx = '0;
    if (in_acc && !ld_pend_q && act == pwltrt_pkg::ACT_EDGE &&
        phase_q == pwltrt_pkg::PH_WAIT && rx_run_q &&
        cap_ext < CMP_W'(REC_DEPTH)) begin
      cap_v   = 1'b1;
      cap_int = edge_q;
      cap_idx = cap_ext[pwltrt_pkg::CapIdxW-1:0];
    end
  end

  // Next state
  always_comb begin
    phase_d   = phase_q;
    line_d    = line_q;
    spos_d    = spos_q;
    pcnt_d    = pcnt_q;
    rx_run_d  = rx_run_q;
    rx_cap_d  = rx_cap_q;
    edge_d    = edge_q;
    ld_pend_d = 1'b0;
    mem_we    = 1'b0;

    if (ld_pend_q) begin
      // first period length arrives from the memory
      pcnt_d = rd_q;
    end else if (in_acc) begin
      unique case (act)
        pwltrt_pkg::ACT_WRITE: begin
          if (entry_ext < CMP_W'(SEND_DEPTH)) begin
            mem_we = 1'b1;
          end
        end
        pwltrt_pkg::ACT_START: begin
          phase_d   = pwltrt_pkg::PH_SEND;
          spos_d    = POS_W'(1);
          rx_run_d  = 1'b0;
          rx_cap_d  = '0;
          edge_d    = '0;
          ld_pend_d = 1'b1;
        end
        pwltrt_pkg::ACT_TICK: begin
          if (phase_q == pwltrt_pkg::PH_SEND || phase_q == pwltrt_pkg::PH_DELAY) begin
            if (pcnt_q <= TW'(1)) begin
              pcnt_d = '0;
              if (phase_q == pwltrt_pkg::PH_SEND) begin
                line_d = ~line_q;
                if (spos_ext < cnt_eff) begin
                  // rd_q already holds the entry for this position
                  pcnt_d = rd_q;
                  spos_d = POS_W'(spos_q + POS_W'(1));
                end else if (!fixed_q && expect_q) begin
                  pcnt_d  = rdelay_q;
                  phase_d = pwltrt_pkg::PH_DELAY;
                end else begin
                  phase_d = pwltrt_pkg::PH_END;
                end
              end else begin
                phase_d  = pwltrt_pkg::PH_WAIT;
                edge_d   = '0;
                rx_run_d = 1'b0;
              end
            end else begin
              pcnt_d = pcnt_q - TW'(1);
            end
          end else if (phase_q == pwltrt_pkg::PH_WAIT && rx_run_q) begin
            edge_d = edge_inc;
            if (edge_inc >= rtimeout_q) begin
              phase_d  = pwltrt_pkg::PH_TIMEOUT;
              rx_run_d = 1'b0;
            end
          end
        end
        pwltrt_pkg::ACT_EDGE: begin
          if (phase_q == pwltrt_pkg::PH_WAIT) begin
            if (!rx_run_q) begin
              rx_run_d = 1'b1;
              edge_d   = '0;
            end else if (cap_v) begin
              rx_cap_d = CAP_W'(rx_cap_q + CAP_W'(1));
              edge_d   = '0;
            end
          end
        end
      endcase
    end
  end

  // Read ahead the entry that the next period end will load; a start reads entry 0
  always_comb begin
    if (ld_pend_d) begin
      mem_raddr = '0;
    end else if (fixed_d) begin
      mem_raddr = AW'(spos_d[0]);
    end else begin
      mem_raddr = spos_d[AW-1:0];
    end
  end

  // Memory: forward a same-cycle write to the read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dur_mem[mem_waddr] <= in_dur;
    end
    if (mem_we && mem_waddr == mem_raddr) begin
      rd_q <= in_dur;
    end else begin
      rd_q <= dur_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= pwltrt_pkg::PH_IDLE;
      line_q    <= 1'b0;
      spos_q    <= '0;
      pcnt_q    <= '0;
      rx_run_q  <= 1'b0;
      rx_cap_q  <= '0;
      edge_q    <= '0;
      ld_pend_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      line_q    <= line_d;
      spos_q    <= spos_d;
      pcnt_q    <= pcnt_d;
      rx_run_q  <= rx_run_d;
      rx_cap_q  <= rx_cap_d;
      edge_q    <= edge_d;
      ld_pend_q <= ld_pend_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: takes a new result whenever the old one is gone or leaving
  // ---------------------------------------------------------------------------
  logic        out_valid_q, out_valid_d;
  logic [47:0] out_data_q;
  logic        out_user_q;

  assign s_axis_tready = !ld_pend_q && (!out_valid_q || m_axis_tready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= {6'b0, cap_idx, cap_int, phase_d, line_d};
      out_user_q <= cap_v;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

[rtl/pwltrt_chk.sv]
// Port-level checker for the pulse-width line timer and its bind.
// Depends on pwltrt_pkg and pulse_width_line_tx_rx_timer_top.
`default_nettype none

module pwltrt_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [1:0]  s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Captures happen only while waiting for the reply
  a_cap_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[3:1] == pwltrt_pkg::PH_WAIT)
    else $error("capture outside the receive window");

  // No capture means zero interval and index
  a_cap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[41:4] == 38'd0)
    else $error("stale capture fields");

  // A start transaction shows the send phase and blocks input for the memory read
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == pwltrt_pkg::ACT_START |=>
      m_axis_tvalid && m_axis_tdata[3:1] == pwltrt_pkg::PH_SEND && !s_axis_tready)
    else $error("start not handled");

endmodule

bind pulse_width_line_tx_rx_timer_top pwltrt_chk u_pwltrt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[tb/sv/pulse_width_line_tx_rx_timer_top_tb.sv]
// Self-checking testbench for pulse_width_line_tx_rx_timer_top: directed and random
// transactions with a built-in line timer predictor checked against every result.
// Depends on pwltrt_pkg and the top level RTL only.

module pulse_width_line_tx_rx_timer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pwltrt_pkg::*;

  localparam int HalfPeriod  = 4;
  localparam int CycleLimit  = 400_000;
  localparam int HoldCycles  = 300;
  localparam int MaxShown    = 10;
  localparam int TblDepth    = 64;
  localparam int ReplyDepth  = 64;
  localparam int RandomItems = 640;

  // One input transaction and one result, unpacked from the stream fields
  typedef struct packed {
    action_e      act;
    logic [5:0]   idx;
    logic [31:0]  dur;
  } timer_cmd_t;

  typedef struct packed {
    logic         line;
    phase_e       ph;
    logic         cv;
    logic [31:0]  ivl;
    logic [5:0]   cidx;
  } line_status_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [39:0]         s_axis_tdata;   // entry_index [5:0], duration_value [37:6]
  logic [1:0]          s_axis_tuser;   // action
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [47:0]         m_axis_tdata;   // line_level [0], phase [3:1],
                                       // capture_interval [35:4], capture_index [41:36]
  logic [0:0]          m_axis_tuser;   // capture_valid
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [TicksW-1:0]   cfg_data_i;

  pulse_width_line_tx_rx_timer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Predictor copy of the configuration registers (reset values)
  logic        fixed_mode  = 1'b0;
  logic [6:0]  pulse_cnt   = '0;
  logic        want_reply  = 1'b0;
  logic [31:0] reply_delay = 32'd1;
  logic [31:0] rx_timeout  = '1;

  // Predictor copy of the sequencer and capture state
  phase_e      cur_phase   = PH_IDLE;
  logic        line_lvl    = 1'b0;
  logic [6:0]  send_pos    = '0;
  logic [31:0] period_left = '0;
  logic        rx_on       = 1'b0;
  logic [6:0]  rx_count    = '0;
  logic [31:0] edge_ticks  = '0;
  logic [31:0] dur_tbl [TblDepth];

  line_status_t pending_status_q[$];

  int  n_sent      = 0;
  int  n_results   = 0;
  int  n_captures  = 0;
  int  n_timeouts  = 0;
  int  fail_count  = 0;
  int  cycle_count = 0;
  bit  no_gaps     = 1'b0;
  bit  hold_req    = 1'b0;

  // Advance the predicted timer by one transaction and return the status it shows
  function automatic line_status_t advance_line_timer(timer_cmd_t cmd);
    line_status_t st;
    logic [6:0]   lim;
    st = '0;
    case (cmd.act)
      ACT_WRITE: begin
        dur_tbl[cmd.idx] = cmd.dur;
      end
      ACT_START: begin
        cur_phase   = PH_SEND;
        period_left = dur_tbl[0];
        send_pos    = 7'd1;
        rx_on       = 1'b0;
        rx_count    = '0;
        edge_ticks  = '0;
      end
      ACT_TICK: begin
        if (cur_phase == PH_SEND || cur_phase == PH_DELAY) begin
          if (period_left <= 32'd1) begin
            period_left = '0;
            if (cur_phase == PH_SEND) begin
              // Period over: toggle the line, then load the next period or move on
              lim      = (pulse_cnt > 7'(TblDepth)) ? 7'(TblDepth) : pulse_cnt;
              line_lvl = ~line_lvl;
              if (send_pos < lim) begin
                period_left = fixed_mode ? dur_tbl[send_pos[0]] : dur_tbl[send_pos[5:0]];
                send_pos++;
              end else if (!fixed_mode && want_reply) begin
                period_left = reply_delay;
                cur_phase   = PH_DELAY;
              end else begin
                cur_phase = PH_END;
              end
            end else begin
              cur_phase  = PH_WAIT;
              edge_ticks = '0;
              rx_on      = 1'b0;
            end
          end else begin
            period_left--;
          end
        end else if (cur_phase == PH_WAIT && rx_on) begin
          edge_ticks++;
          if (edge_ticks >= rx_timeout) begin
            cur_phase = PH_TIMEOUT;
            rx_on     = 1'b0;
            n_timeouts++;
          end
        end
      end
      default: begin
        // Receive edge: only the waiting phase listens
        if (cur_phase == PH_WAIT) begin
          if (!rx_on) begin
            rx_on      = 1'b1;
            edge_ticks = '0;
          end else if (rx_count < 7'(ReplyDepth)) begin
            st.cv      = 1'b1;
            st.ivl     = edge_ticks;
            st.cidx    = rx_count[5:0];
            rx_count++;
            edge_ticks = '0;
          end
        end
      end
    endcase
    st.line = line_lvl;
    st.ph   = cur_phase;
    return st;
  endfunction

  // Offer one transaction after a random gap, hold it until accepted, then predict it
  task automatic send_item(action_e act, logic [5:0] idx, logic [31:0] dur);
    timer_cmd_t cmd;
    int         gap;
    cmd = '{act: act, idx: idx, dur: dur};
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, dur, idx};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_status_q.push_back(advance_line_timer(cmd));
    n_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(ACT_TICK, 6'($urandom), $urandom);
  endtask

  task automatic send_edge();
    send_item(ACT_EDGE, 6'($urandom), $urandom);
  endtask

  // Mostly short durations; long ones only land at entries 8 and above
  task automatic send_random_write();
    logic [5:0]  idx;
    logic [31:0] dur;
    idx = 6'($urandom_range(0, TblDepth - 1));
    dur = 32'($urandom_range(1, 4));
    if (idx >= 6'd8 && $urandom_range(0, 3) == 0) begin
      dur = $urandom;
      if (dur == '0) dur = 32'd1;
    end
    send_item(ACT_WRITE, idx, dur);
  endtask

  // Drop valid, wait until every result is back, and let the pipeline empty
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write all five registers while idle and mirror them in the predictor
  task automatic configure(logic fixed, logic [6:0] cnt, logic reply,
                           logic [31:0] delay, logic [31:0] tmo);
    logic [CfgIdxW-1:0] idx_list [5];
    logic [31:0]        val_list [5];
    settle();
    idx_list = '{CFG_FIXED_MODE, CFG_PULSE_COUNT, CFG_EXPECT_REPLY,
                 CFG_REPLY_DELAY, CFG_RX_TIMEOUT};
    val_list = '{32'(fixed), 32'(cnt), 32'(reply), delay, tmo};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx_list[i];
      cfg_data_i <= val_list[i];
    end
    fixed_mode  = fixed;
    pulse_cnt   = cnt;
    want_reply  = reply;
    reply_delay = delay;
    rx_timeout  = tmo;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Fill the whole duration table so no send ever reads an unwritten entry
  task automatic test_table_load();
    for (int i = 0; i < TblDepth; i++)
      send_item(ACT_WRITE, 6'(i), (i == 1) ? 32'd2 : 32'd1);
  endtask

  // Ticks and edges in idle and end are ignored; field extremes on writes
  task automatic test_stray_events();
    send_ticks(2);
    send_edge();
    send_item(ACT_WRITE, 6'd63, 32'hFFFF_FFFF);
    send_item(ACT_WRITE, 6'd0, 32'd1);
    send_item(ACT_START, 6'd63, 32'hFFFF_FFFF);
    send_ticks(3);
    send_edge();
    send_item(ACT_WRITE, 6'd63, 32'd1);
  endtask

  // Variable send with a reply: a few captured intervals, then restart while waiting
  task automatic test_reply_capture();
    configure(1'b0, 7'd2, 1'b1, 32'd1, 32'hFFFF_FFFF);
    send_item(ACT_START, '0, '0);
    send_edge();
    send_ticks(4);
    send_edge();
    send_ticks(3);
    send_edge();
    send_edge();
    send_ticks(1);
    send_edge();
    send_item(ACT_WRITE, 6'd1, 32'd3);
    send_item(ACT_START, '1, '1);
    send_ticks(5);
  endtask

  // Shortest timeout, then stray events in the timeout phase and a restart from it
  task automatic test_rx_timeout();
    configure(1'b0, 7'd1, 1'b1, 32'd3, 32'd1);
    send_item(ACT_START, '0, '0);
    send_ticks(5);
    send_edge();
    send_ticks(2);
    send_edge();
    send_item(ACT_START, '0, '0);
    send_ticks(5);
    send_edge();
    send_ticks(1);
    send_edge();
  endtask

  // Fixed mode alternates entries 0 and 1 and never opens a receive window
  task automatic test_fixed_mode();
    configure(1'b1, 7'd5, 1'b1, 32'd1, 32'd4);
    send_item(ACT_START, '0, '0);
    send_ticks(6);
    send_item(ACT_START, '0, '0);
    send_ticks(12);
    send_edge();
    configure(1'b1, 7'd0, 1'b0, 32'd1, 32'd4);
    send_item(ACT_START, '0, '0);
    send_ticks(2);
  endtask

  // Fill the reply: edges past the capture depth are dropped, the counter goes on
  task automatic test_reply_full();
    configure(1'b0, 7'd1, 1'b1, 32'd1, 32'd200);
    send_item(ACT_START, '0, '0);
    send_ticks(2);
    send_edge();
    repeat (ReplyDepth + 3) begin
      send_ticks($urandom_range(0, 2));
      send_edge();
    end
    send_ticks(210);
  endtask

  // All periods of the table, the longest reply delay, and a long receiver hold-off
  task automatic test_long_send();
    configure(1'b0, 7'd64, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    send_item(ACT_START, '0, '0);
    send_ticks(120);
    no_gaps = 1'b0;
    send_ticks(40);
    send_edge();
  endtask

  // Random configurations with mostly well-formed start/tick/edge sequences
  task automatic test_random();
    int target;
    int per_round;
    logic [6:0] cnt;
    per_round = RandomItems / 8;
    for (int round = 0; round < 8; round++) begin
      cnt = ($urandom_range(0, 7) == 0) ? 7'd64 : 7'($urandom_range(0, 6));
      configure($urandom_range(0, 3) == 0, cnt, $urandom_range(0, 3) != 0,
                ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 6)),
                ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 30)));
      no_gaps = (round % 4 == 3);
      target  = n_sent + per_round;
      while (n_sent < target) begin
        if ($urandom_range(0, 9) == 0) begin
          // Noise: any action with random content
          if ($urandom_range(0, 3) == 0) send_random_write();
          else send_item(action_e'($urandom_range(1, 3)), 6'($urandom), $urandom);
        end else begin
          repeat ($urandom_range(0, 2)) send_random_write();
          send_item(ACT_START, 6'($urandom), $urandom);
          repeat ($urandom_range(8, 40)) begin
            if ($urandom_range(0, 2) == 0) send_edge();
            else send_ticks(1);
          end
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  // Result side: random stalls, one long hold-off on request, check every transaction
  initial begin
    int           stall;
    line_status_t want_st;
    line_status_t got_st;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      stall = no_gaps ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got_st.line = m_axis_tdata[0];
      got_st.ph   = phase_e'(m_axis_tdata[3:1]);
      got_st.ivl  = m_axis_tdata[35:4];
      got_st.cidx = m_axis_tdata[41:36];
      got_st.cv   = m_axis_tuser[0];
      n_results++;
      if (pending_status_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxShown)
          $display("unexpected result %0d: line %0b phase %0d cv %0b ivl %0d idx %0d",
                   n_results, got_st.line, got_st.ph, got_st.cv, got_st.ivl, got_st.cidx);
      end else begin
        want_st = pending_status_q.pop_front();
        if (want_st.cv) n_captures++;
        if (got_st.line !== want_st.line || got_st.ph !== want_st.ph ||
            got_st.cv !== want_st.cv || got_st.ivl !== want_st.ivl ||
            got_st.cidx !== want_st.cidx) begin
          fail_count++;
          if (fail_count <= MaxShown)
            $display("mismatch at result %0d: exp line %0b phase %0d cv %0b ivl %0d idx %0d",
                     n_results, want_st.line, want_st.ph, want_st.cv, want_st.ivl,
                     want_st.cidx, " / got line %0b phase %0d cv %0b ivl %0d idx %0d",
                     got_st.line, got_st.ph, got_st.cv, got_st.ivl, got_st.cidx);
        end
      end
    end
  end

  // Watchdog: stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_status_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_WRITE;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_FIXED_MODE;
    cfg_data_i    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_table_load();
    test_stray_events();
    test_reply_capture();
    test_rx_timeout();
    test_fixed_mode();
    test_reply_full();
    test_long_send();
    test_random();

    settle();
    repeat (8) @(posedge clk_i);
    $display("run covered %0d transactions and %0d results in %0d cycles",
             n_sent, n_results, cycle_count);
    $display("reply intervals captured: %0d, receive timeouts: %0d, failures: %0d",
             n_captures, n_timeouts, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
